>>> sv/lfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfe_pkg
// Shared types, widths and fixed-point constants of the Langermann fitness
// evaluator: centres, weights and the reciprocal tables for the Horner steps.
// ----------------------------------------------------------------------------
package lfe_pkg;

  localparam int NTERM     = 5;
  localparam int COORD_W   = 22;
  localparam int DELTA_W   = 23;
  localparam int TERM_W    = 24;
  localparam int SUM_W     = 27;
  localparam int OUT_W     = 26;
  localparam int EXP_STEPS = 10;
  localparam int COS_STEPS = 6;
  localparam int LANE_LAT  = 38;
  localparam int BACK_LAT  = LANE_LAT + 1;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;

  // fixed-point constants
  localparam logic [28:0] ONE_Q28    = 29'h1000_0000;
  localparam logic [28:0] INV_PI_Q30 = 29'h145F_306E;
  localparam logic [30:0] LOG2E_Q30  = 31'h5C55_1D95;
  localparam logic [29:0] LN2_Q30    = 30'h2C5C_85FE;
  localparam logic [30:0] TWO_PI_Q28 = 31'h6487_ED51;
  localparam logic [44:0] R_LIMIT    = 45'h28_0000_0000;

  localparam logic signed [SUM_W-1:0] OUT_MAX = 27'sd33554431;
  localparam logic signed [SUM_W-1:0] OUT_MIN = -27'sd33554432;

  typedef struct packed {
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
  } lfe_delta_t;

  typedef lfe_delta_t [NTERM-1:0] lfe_item_t;

  // centre coordinates in Q5.16
  function automatic logic signed [DELTA_W-1:0] centre_x(input int i);
    case (i)
      0:       centre_x = 23'sd196608;
      1:       centre_x = 23'sd327680;
      2:       centre_x = 23'sd131072;
      3:       centre_x = 23'sd65536;
      4:       centre_x = 23'sd458752;
      default: centre_x = 23'sd0;
    endcase
  endfunction

  function automatic logic signed [DELTA_W-1:0] centre_y(input int i);
    case (i)
      0:       centre_y = 23'sd327680;
      1:       centre_y = 23'sd131072;
      2:       centre_y = 23'sd65536;
      3:       centre_y = 23'sd262144;
      4:       centre_y = 23'sd589824;
      default: centre_y = 23'sd0;
    endcase
  endfunction

  function automatic logic [2:0] weight(input int i);
    case (i)
      0:       weight = 3'd1;
      1:       weight = 3'd2;
      2:       weight = 3'd5;
      3:       weight = 3'd2;
      4:       weight = 3'd3;
      default: weight = 3'd0;
    endcase
  endfunction

  // exp Horner divisor, k runs 10 down to 1
  function automatic int exp_k(input int j);
    exp_k = EXP_STEPS - j;
  endfunction

  // floor(2^30 / k) for the exp Horner divisors
  function automatic logic [30:0] exp_recip(input int j);
    case (j)
      0:       exp_recip = 31'd107374182;
      1:       exp_recip = 31'd119304647;
      2:       exp_recip = 31'd134217728;
      3:       exp_recip = 31'd153391689;
      4:       exp_recip = 31'd178956970;
      5:       exp_recip = 31'd214748364;
      6:       exp_recip = 31'd268435456;
      7:       exp_recip = 31'd357913941;
      8:       exp_recip = 31'd536870912;
      9:       exp_recip = 31'd1073741824;
      default: exp_recip = 31'd0;
    endcase
  endfunction

  // cos Horner divisor (2k)(2k-1), k runs 7 down to 2
  function automatic int cos_k(input int j);
    case (j)
      0:       cos_k = 182;
      1:       cos_k = 132;
      2:       cos_k = 90;
      3:       cos_k = 56;
      4:       cos_k = 30;
      5:       cos_k = 12;
      default: cos_k = 1;
    endcase
  endfunction

  function automatic logic [30:0] cos_recip(input int j);
    case (j)
      0:       cos_recip = 31'd5899680;
      1:       cos_recip = 31'd8134407;
      2:       cos_recip = 31'd11930464;
      3:       cos_recip = 31'd19173961;
      4:       cos_recip = 31'd35791394;
      5:       cos_recip = 31'd89478485;
      default: cos_recip = 31'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

>>> sv/langermann_fitness_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// langermann_fitness_eval
// Negated two-dimensional five-term Langermann function in fixed point.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    in_coord_x, in_coord_y (Q5.16)
//   out_     output     out_valid/out_ready  out_fitness_value (Q5.20)
//
// One point per cycle sustained unless the output stalls. Latency from
// acceptance to out_valid is set by the ten-step exponential Horner chain
// in each term lane. Reset clears the queue and the valid bits only.
// An output stall freezes the execution pipeline; the four-entry queue
// keeps taking points until it fills, then in_ready drops.
// ----------------------------------------------------------------------------
module langermann_fitness_eval import lfe_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [OUT_W-1:0]   out_fitness_value
);

  logic      q_push, q_pop, q_full, q_empty;
  lfe_item_t q_wr_data, q_rd_data;

  // front: accept and form offsets
  lfe_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_coord_x (in_coord_x),
    .in_coord_y (in_coord_y),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wr_data)
  );

  // decoupling queue
  lfe_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // back: term lanes, sum and output register
  lfe_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_data            (q_rd_data),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_fitness_value (out_fitness_value)
  );

endmodule
`default_nettype wire

>>> sv/lfe_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfe_front
// Input side: takes a point, forms its offsets to the five centres and
// pushes them into the queue while there is room.
// ----------------------------------------------------------------------------
module lfe_front import lfe_pkg::*; (
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  input  logic                      q_full,
  output logic                      q_push,
  output lfe_item_t                 q_data
);

  // handshake against queue room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // offsets to each centre
  always_comb begin
    for (int i = 0; i < NTERM; i++) begin
      q_data[i].dx = DELTA_W'(in_coord_x) - centre_x(i);
      q_data[i].dy = DELTA_W'(in_coord_y) - centre_y(i);
    end
  end

endmodule
`default_nettype wire

>>> sv/lfe_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfe_queue
// Four-entry queue between the front and the back; head is visible
// combinationally so the back can pop every cycle.
// ----------------------------------------------------------------------------
module lfe_queue import lfe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  lfe_item_t wr_data,
  output logic      full,
  input  logic      pop,
  output lfe_item_t rd_data,
  output logic      empty
);

  lfe_item_t          slot_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QPTR_W:0]    cnt_r;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, pop};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= wr_data;
  end

  assign rd_data = slot_r[rd_ptr_r];
  assign full    = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);

endmodule
`default_nettype wire

>>> sv/lfe_term.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfe_term
// One Langermann term lane: squared distance, exp(-r/pi) by range split and
// a ten-step Horner chain, cos(pi*r) by folding and a six-step Horner chain,
// weighted rounded product. Fixed 38-stage pipeline, advances on en.
// ----------------------------------------------------------------------------
module lfe_term import lfe_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  lfe_delta_t               delta,
  input  logic [2:0]               wt,
  output logic signed [TERM_W-1:0] term
);

  localparam int CDLY = 11;
  localparam int FDLY = 34;

  // absolute offsets
  logic signed [DELTA_W-1:0] ndx, ndy;
  logic [21:0]               adx, ady;
  assign ndx = -delta.dx;
  assign ndy = -delta.dy;
  assign adx = delta.dx[DELTA_W-1] ? ndx[21:0] : delta.dx[21:0];
  assign ady = delta.dy[DELTA_W-1] ? ndy[21:0] : delta.dy[21:0];

  // squares
  logic [43:0] sqx_r, sqy_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r <= adx * adx;
      sqy_r <= ady * ady;
    end
  end

  // squared distance and far flag
  logic [44:0] rsum;
  logic [37:0] r_r;
  logic        far_r;
  assign rsum = {1'b0, sqx_r} + {1'b0, sqy_r};
  always_ff @(posedge clk) begin
    if (en) begin
      r_r   <= rsum[37:0];
      far_r <= (rsum > R_LIMIT);
    end
  end

  // ---------------- exponential path ----------------
  logic [62:0] e1_prod, e2_prod;
  logic [57:0] e3_prod;
  logic [31:0] t_r;
  logic [32:0] u_r;
  logic [27:0] eg_r [EXP_STEPS+1];
  logic [4:0]  xn_r [EXP_STEPS+1];
  logic [28:0] ep_r [EXP_STEPS+1];
  logic [28:0] e_r;

  assign e1_prod = r_r[37:4] * INV_PI_Q30;
  assign e2_prod = t_r * LOG2E_Q30;
  assign e3_prod = u_r[27:0] * LN2_Q30;

  // r/pi, then times log2 e, then split into shift and fraction
  always_ff @(posedge clk) begin
    if (en) begin
      t_r     <= e1_prod[61:30];
      u_r     <= e2_prod[62:30];
      eg_r[0] <= e3_prod[57:30];
      xn_r[0] <= u_r[32:28];
      ep_r[0] <= ONE_Q28;
    end
  end

  // Horner steps for e^-g, three stages each
  for (genvar j = 0; j < EXP_STEPS; j++) begin : g_exp
    localparam int          K = exp_k(j);
    localparam logic [30:0] M = exp_recip(j);
    logic [56:0] a_prod;
    logic [58:0] b_prod;
    logic [27:0] a_m_r, a_g_r, b_m_r, b_g_r, b_q_r;
    logic [4:0]  a_n_r, b_n_r;
    logic [27:0] rem, q;

    assign a_prod = eg_r[j] * ep_r[j];
    assign b_prod = a_m_r * M;
    assign rem    = b_m_r - 28'(b_q_r * K);
    assign q      = b_q_r + {27'd0, (rem >= 28'(K))};

    always_ff @(posedge clk) begin
      if (en) begin
        a_m_r       <= a_prod[55:28];
        a_g_r       <= eg_r[j];
        a_n_r       <= xn_r[j];
        b_q_r       <= b_prod[57:30];
        b_m_r       <= a_m_r;
        b_g_r       <= a_g_r;
        b_n_r       <= a_n_r;
        ep_r[j+1]   <= ONE_Q28 - {1'b0, q};
        eg_r[j+1]   <= b_g_r;
        xn_r[j+1]   <= b_n_r;
      end
    end
  end

  // scale by 2^-n
  always_ff @(posedge clk) begin
    if (en) e_r <= ep_r[EXP_STEPS] >> xn_r[EXP_STEPS];
  end

  // ---------------- cosine path ----------------
  logic [31:0] h0;
  logic [32:0] h1, h2;
  logic        hneg;
  logic [30:0] ch_r;
  logic        ch_neg_r, th_neg_r;
  logic [61:0] c2_prod;
  logic [57:0] c3_prod;
  logic [28:0] th_r;
  logic [29:0] cs_r [COS_STEPS+1];
  logic        cn_r [COS_STEPS+1];
  logic [28:0] cp_r [COS_STEPS+1];

  // fold the phase into the first quarter turn
  assign h0   = r_r[32:1];
  assign h1   = (h0 > 32'h8000_0000) ? (33'h1_0000_0000 - {1'b0, h0}) : {1'b0, h0};
  assign hneg = (h1 > 33'h0_4000_0000);
  assign h2   = hneg ? (33'h0_8000_0000 - h1) : h1;

  assign c2_prod = ch_r * TWO_PI_Q28;
  assign c3_prod = th_r * th_r;

  // phase, angle, angle squared
  always_ff @(posedge clk) begin
    if (en) begin
      ch_r     <= h2[30:0];
      ch_neg_r <= hneg;
      th_r     <= c2_prod[60:32];
      th_neg_r <= ch_neg_r;
      cs_r[0]  <= c3_prod[57:28];
      cn_r[0]  <= th_neg_r;
      cp_r[0]  <= ONE_Q28;
    end
  end

  // Horner steps for the cosine series, three stages each
  for (genvar j = 0; j < COS_STEPS; j++) begin : g_cos
    localparam int          K = cos_k(j);
    localparam logic [30:0] M = cos_recip(j);
    logic [58:0] a_prod;
    logic [60:0] b_prod;
    logic [29:0] a_m_r, a_s_r, b_m_r, b_s_r;
    logic [27:0] b_q_r;
    logic        a_n_r, b_n_r;
    logic [29:0] rem;
    logic [27:0] q;

    assign a_prod = cs_r[j] * cp_r[j];
    assign b_prod = a_m_r * M;
    assign rem    = b_m_r - 30'(b_q_r * K);
    assign q      = b_q_r + {27'd0, (rem >= 30'(K))};

    always_ff @(posedge clk) begin
      if (en) begin
        a_m_r     <= a_prod[57:28];
        a_s_r     <= cs_r[j];
        a_n_r     <= cn_r[j];
        b_q_r     <= b_prod[57:30];
        b_m_r     <= a_m_r;
        b_s_r     <= a_s_r;
        b_n_r     <= a_n_r;
        cp_r[j+1] <= ONE_Q28 - {1'b0, q};
        cs_r[j+1] <= b_s_r;
        cn_r[j+1] <= b_n_r;
      end
    end
  end

  // last series step, halving
  logic [58:0]        f_prod;
  logic [29:0]        cm_r;
  logic               cf_neg_r;
  logic signed [30:0] cval, cabs;
  assign f_prod = cs_r[COS_STEPS] * cp_r[COS_STEPS];
  assign cval   = $signed({2'b00, ONE_Q28}) - $signed({2'b00, cm_r[29:1]});
  assign cabs   = cval[30] ? -cval : cval;

  // cosine magnitude and sign, delayed to meet the exp result
  logic [28:0] cdm_r [CDLY+1];
  logic        cds_r [CDLY+1];
  logic        fd_r  [FDLY];
  always_ff @(posedge clk) begin
    if (en) begin
      cm_r     <= f_prod[57:28];
      cf_neg_r <= cn_r[COS_STEPS];
      cdm_r[0] <= cabs[28:0];
      cds_r[0] <= cf_neg_r ^ cval[30];
      for (int k = 1; k <= CDLY; k++) begin
        cdm_r[k] <= cdm_r[k-1];
        cds_r[k] <= cds_r[k-1];
      end
      fd_r[0] <= far_r;
      for (int k = 1; k < FDLY; k++) begin
        fd_r[k] <= fd_r[k-1];
      end
    end
  end

  // ---------------- term ----------------
  logic [57:0] tp_prod, tp_r;
  logic        tsgn_r, tfar_r;
  logic [60:0] w_prod, w_rnd;
  logic [22:0] tmag;
  logic signed [TERM_W-1:0] term_r;

  assign tp_prod = e_r * cdm_r[CDLY];
  assign w_prod  = tp_r * wt;
  assign w_rnd   = w_prod + 61'h8_0000_0000;
  assign tmag    = w_rnd[58:36];

  always_ff @(posedge clk) begin
    if (en) begin
      tp_r   <= tp_prod;
      tsgn_r <= cds_r[CDLY];
      tfar_r <= fd_r[FDLY-1];
      if (tfar_r) begin
        term_r <= '0;
      end else if (tsgn_r) begin
        term_r <= -$signed({1'b0, tmag});
      end else begin
        term_r <= $signed({1'b0, tmag});
      end
    end
  end

  assign term = term_r;

endmodule
`default_nettype wire

>>> sv/lfe_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfe_back
// Execution side: pops queued offsets, runs five term lanes, sums,
// negates with saturation and holds the result in the output register.
// ----------------------------------------------------------------------------
module lfe_back import lfe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lfe_item_t             q_data,
  input  logic                  q_empty,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [OUT_W-1:0] out_fitness_value
);

  localparam logic signed [SUM_W-1:0] SUM_BOUND = 27'sd15728640;

  logic [BACK_LAT-1:0]       vld_r;
  logic                      en;
  logic                      out_valid_r;
  logic signed [OUT_W-1:0]   out_fitness_value_r;
  logic signed [TERM_W-1:0]  terms [NTERM];
  logic signed [SUM_W-1:0]   sum_nxt, sum_r, neg_sum;
  logic signed [OUT_W-1:0]   sat_val;

  // pipeline stalls only when a finished result cannot move out
  assign en    = !(vld_r[BACK_LAT-1] && out_valid_r && !out_ready);
  assign q_pop = en && !q_empty;

  // valid tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[BACK_LAT-2:0], q_pop};
    end
  end

  // term lanes
  for (genvar i = 0; i < NTERM; i++) begin : g_lane
    lfe_term u_term (
      .clk   (clk),
      .en    (en),
      .delta (q_data[i]),
      .wt    (weight(i)),
      .term  (terms[i])
    );
  end

  // sum of terms
  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NTERM; i++) begin
      sum_nxt = sum_nxt + SUM_W'(terms[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) sum_r <= sum_nxt;
  end

  // negate and saturate
  assign neg_sum = -sum_r;
  always_comb begin
    if (neg_sum > OUT_MAX) begin
      sat_val = OUT_MAX[OUT_W-1:0];
    end else if (neg_sum < OUT_MIN) begin
      sat_val = OUT_MIN[OUT_W-1:0];
    end else begin
      sat_val = neg_sum[OUT_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && vld_r[BACK_LAT-1]) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld_r[BACK_LAT-1]) out_fitness_value_r <= sat_val;
  end

  assign out_valid         = out_valid_r;
  assign out_fitness_value = out_fitness_value_r;

`ifndef ASSERT_OFF
  // a stalled pipeline keeps its occupancy
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("valid bits moved during stall");

  // a result leaving the pipeline lands in the output register
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[BACK_LAT-1] |=> out_valid_r)
    else $error("finished transaction lost at output");

  // five weighted terms stay within 15 units
  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[BACK_LAT-1] |-> (sum_r <= SUM_BOUND) && (sum_r >= -SUM_BOUND))
    else $error("term sum out of bound");
`endif

endmodule
`default_nettype wire
